### rtl/core/priority_ready_queue_scheduler_core_defines.svh
// Assertion macros for the scheduler core.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PRQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler core assertion failed");
// next-cycle implication
`define PRQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler core assertion failed");
`else
`define PRQS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PRQS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/prqs_pkg.sv
// Shared constants, codes and types of the ready queue scheduler.
package prqs_pkg;

  localparam int LEVELS    = 4;
  localparam int MAX_SLOTS = 16;

  localparam int LVL_W    = $clog2(LEVELS);
  localparam int SLOT_W   = $clog2(MAX_SLOTS);
  localparam int CNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int ACT_W    = 3;
  localparam int ID_W     = 4;
  localparam int PRIO_W   = 2;
  localparam int QST_W    = 2;
  localparam int LIVE_W   = 5;
  localparam int LIVE_MAX = 31;

  localparam logic [ACT_W-1:0] ACT_CREATE     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ACTIVATE   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_YIELD      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEACTIVATE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_EXIT       = 3'd4;
  localparam logic [ACT_W-1:0] ACT_QUERY      = 3'd5;

  typedef enum logic [QST_W-1:0] {
    ST_BLOCKED = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_FREE    = 2'd3
  } slot_state_t;

  typedef struct packed {
    logic [LVL_W-1:0] prio;
    slot_state_t      state;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [LVL_W-1:0]  lv;
    logic [SLOT_W-1:0] slot;
  } enq_req_t;

  typedef struct packed {
    logic              en;
    logic [LVL_W-1:0]  lv;
    logic              last;
    logic [SLOT_W-1:0] nxt_head;
  } pop_req_t;

  typedef struct packed {
    logic              any;
    logic [LVL_W-1:0]  lv;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
  } lvl_sel_t;

  function automatic logic [LVL_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
    if (int'(p) >= LEVELS) begin
      return LVL_W'(LEVELS - 1);
    end
    return LVL_W'(p);
  endfunction

endpackage

### rtl/core/prqs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module prqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/prqs_level_tbl.sv
// Per-level head/tail/non-empty table and highest-level select.
module prqs_level_tbl import prqs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  enq_req_t          enq_i,
  input  pop_req_t          pop_i,
  output logic              enq_nonempty_o,
  output logic [SLOT_W-1:0] enq_tail_o,
  output lvl_sel_t          sel_o
);

  logic [SLOT_W-1:0] head_r [LEVELS];
  logic [SLOT_W-1:0] tail_r [LEVELS];
  logic [LEVELS-1:0] ne_r;

  logic [SLOT_W-1:0] head_v [LEVELS];
  logic [SLOT_W-1:0] tail_v [LEVELS];
  logic [LEVELS-1:0] ne_v;
  logic [LVL_W-1:0]  top_lv;

  assign enq_nonempty_o = ne_r[enq_i.lv];
  assign enq_tail_o     = tail_r[enq_i.lv];

  // view after this cycle's enqueue, so dispatch can follow it at once
  always_comb begin
    ne_v = ne_r;
    for (int l = 0; l < LEVELS; l++) begin
      head_v[l] = head_r[l];
      tail_v[l] = tail_r[l];
      if (enq_i.en && enq_i.lv == LVL_W'(l)) begin
        tail_v[l] = enq_i.slot;
        if (!ne_r[l]) begin
          head_v[l] = enq_i.slot;
        end
        ne_v[l] = 1'b1;
      end
    end
  end

  always_comb begin
    top_lv = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (ne_v[l]) begin
        top_lv = LVL_W'(l);
      end
    end
    sel_o.any  = |ne_v;
    sel_o.lv   = top_lv;
    sel_o.head = head_v[top_lv];
    sel_o.tail = tail_v[top_lv];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r <= '0;
    end else begin
      if (enq_i.en) begin
        ne_r[enq_i.lv] <= 1'b1;
      end
      if (pop_i.en && pop_i.last) begin
        ne_r[pop_i.lv] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enq_i.en) begin
      tail_r[enq_i.lv] <= enq_i.slot;
      if (!ne_r[enq_i.lv]) begin
        head_r[enq_i.lv] <= enq_i.slot;
      end
    end
    if (pop_i.en && !pop_i.last) begin
      head_r[pop_i.lv] <= pop_i.nxt_head;
    end
  end

endmodule

### rtl/core/priority_ready_queue_scheduler_core.sv
// Top level of the multilevel priority ready queue scheduler.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, action, id, priority | input
//  out     | out_valid/out_ready, status word        | output
//
// Each word goes through S_EXEC to read the slot and link memories (and
// apply the running thread's change), S_DONE to commit and load the result.
// The link memory read for dispatch sets the pace; a new word is taken in
// the commit cycle. Reset clears slot state via per-slot valid bits, no
// sweep. A full output register holds the commit cycle until out_ready.
`include "priority_ready_queue_scheduler_core_defines.svh"

module priority_ready_queue_scheduler_core import prqs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [ID_W-1:0]   in_thread_id,
  input  logic [PRIO_W-1:0] in_priority_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_running_id,
  output logic              out_running_present,
  output logic              out_empty_error,
  output logic              out_misuse_flag,
  output logic [QST_W-1:0]  out_queried_state,
  output logic [PRIO_W-1:0] out_queried_priority,
  output logic [LIVE_W-1:0] out_live_threads
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DONE} state_t;

  state_t state_r;

  // accepted word
  logic [ACT_W-1:0]  act_r;
  logic [SLOT_W-1:0] id_r;
  logic [LVL_W-1:0]  prio_r;
  logic              id_ok_r;

  // scheduler status
  logic [SLOT_W-1:0] cur_id_r, cur_id_nxt;
  logic [LVL_W-1:0]  cur_prio_r, cur_prio_nxt;
  logic              cur_present_r, cur_present_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [MAX_SLOTS-1:0] slot_vld_r;
  logic              rd_vld_r;

  // dispatch capture
  logic              dsp_any_r;
  logic [LVL_W-1:0]  dsp_lv_r;
  logic [SLOT_W-1:0] dsp_head_r;
  logic              dsp_last_r;
  logic              fwd_hit_r;
  logic [SLOT_W-1:0] fwd_data_r;

  // output register
  logic              out_valid_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_present_r;
  logic              out_err_r;
  logic              out_misuse_r;
  logic [QST_W-1:0]  out_qst_r;
  logic [PRIO_W-1:0] out_qprio_r;
  logic [LIVE_W-1:0] out_live_r;

  logic        is_dsp, out_free, commit, in_fire;
  enq_req_t    enq;
  pop_req_t    pop;
  lvl_sel_t    sel;
  logic              enq_nonempty;
  logic [SLOT_W-1:0] enq_tail;

  logic              slot_we, slot_re;
  logic [SLOT_W-1:0] slot_waddr;
  slot_entry_t       slot_wdata;
  logic [$bits(slot_entry_t)-1:0] slot_rword;
  slot_entry_t       slot_rd;
  slot_state_t       rd_state;

  logic              link_we, link_re;
  logic [SLOT_W-1:0] link_rd, link_nxt_head;

  logic        empty_err, misuse;
  slot_state_t q_state;
  logic [PRIO_W-1:0] q_prio;

  assign is_dsp   = (act_r == ACT_YIELD) || (act_r == ACT_DEACTIVATE) || (act_r == ACT_EXIT);
  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == S_DONE) && out_free;
  assign in_ready = (state_r == S_IDLE) || commit;
  assign in_fire  = in_valid && in_ready;

  assign slot_re  = (state_r == S_EXEC) && !is_dsp && id_ok_r;
  assign slot_rd  = slot_entry_t'(slot_rword);
  assign rd_state = rd_vld_r ? slot_rd.state : ST_FREE;

  assign link_we       = enq.en && enq_nonempty;
  assign link_re       = (state_r == S_EXEC) && is_dsp;
  assign link_nxt_head = fwd_hit_r ? fwd_data_r : link_rd;

  prqs_ram #(.WIDTH($bits(slot_entry_t)), .DEPTH(MAX_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (id_r),
    .rdata (slot_rword)
  );

  prqs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (enq_tail),
    .wdata (enq.slot),
    .re    (link_re),
    .raddr (sel.head),
    .rdata (link_rd)
  );

  prqs_level_tbl u_level_tbl (
    .clk            (clk),
    .rst_n          (rst_n),
    .enq_i          (enq),
    .pop_i          (pop),
    .enq_nonempty_o (enq_nonempty),
    .enq_tail_o     (enq_tail),
    .sel_o          (sel)
  );

  always_comb begin
    enq             = '0;
    pop             = '0;
    slot_we         = 1'b0;
    slot_waddr      = cur_id_r;
    slot_wdata      = '{prio: cur_prio_r, state: ST_READY};
    cur_id_nxt      = cur_id_r;
    cur_prio_nxt    = cur_prio_r;
    cur_present_nxt = cur_present_r;
    count_nxt       = count_r;
    empty_err       = 1'b0;
    misuse          = 1'b0;
    q_state         = ST_BLOCKED;
    q_prio          = '0;

    // running thread leaves: requeue, block or free it
    if (state_r == S_EXEC && is_dsp && cur_present_r) begin
      slot_we = 1'b1;
      case (act_r)
        ACT_YIELD: begin
          slot_wdata.state = ST_READY;
          enq.en   = 1'b1;
          enq.lv   = cur_prio_r;
          enq.slot = cur_id_r;
        end
        ACT_DEACTIVATE: begin
          slot_wdata.state = ST_BLOCKED;
        end
        default: begin
          slot_wdata.state = ST_FREE;
          if (count_r != '0) begin
            count_nxt = count_r - 1'b1;
          end
        end
      endcase
    end

    if (commit) begin
      unique case (act_r) inside
        ACT_CREATE: begin
          if (id_ok_r && rd_state == ST_FREE) begin
            slot_we    = 1'b1;
            slot_waddr = id_r;
            slot_wdata = '{prio: prio_r, state: ST_READY};
            enq.en     = 1'b1;
            enq.lv     = prio_r;
            enq.slot   = id_r;
            count_nxt  = count_r + 1'b1;
          end
        end
        ACT_ACTIVATE: begin
          if (id_ok_r && rd_state == ST_READY) begin
            misuse = 1'b1;
          end else if (id_ok_r && rd_state == ST_BLOCKED) begin
            slot_we    = 1'b1;
            slot_waddr = id_r;
            slot_wdata = '{prio: slot_rd.prio, state: ST_READY};
            enq.en     = 1'b1;
            enq.lv     = slot_rd.prio;
            enq.slot   = id_r;
          end
        end
        ACT_YIELD, ACT_DEACTIVATE, ACT_EXIT: begin
          if (dsp_any_r) begin
            pop.en          = 1'b1;
            pop.lv          = dsp_lv_r;
            pop.last        = dsp_last_r;
            pop.nxt_head    = link_nxt_head;
            slot_we         = 1'b1;
            slot_waddr      = dsp_head_r;
            slot_wdata      = '{prio: dsp_lv_r, state: ST_RUNNING};
            cur_id_nxt      = dsp_head_r;
            cur_prio_nxt    = dsp_lv_r;
            cur_present_nxt = 1'b1;
          end else begin
            cur_id_nxt      = '0;
            cur_present_nxt = 1'b0;
            empty_err       = 1'b1;
          end
        end
        ACT_QUERY: begin
          if (id_ok_r && rd_state != ST_FREE) begin
            q_state = rd_state;
            q_prio  = PRIO_W'(slot_rd.prio);
          end else begin
            q_state = ST_FREE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // capture of word, slot read valid and dispatch choice
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r   <= in_action;
      id_r    <= SLOT_W'(in_thread_id);
      prio_r  <= clamp_prio(in_priority_req);
      id_ok_r <= (32'(in_thread_id) < 32'(MAX_SLOTS));
    end
    if (state_r == S_EXEC) begin
      rd_vld_r   <= slot_vld_r[id_r];
      dsp_any_r  <= sel.any;
      dsp_lv_r   <= sel.lv;
      dsp_head_r <= sel.head;
      dsp_last_r <= (sel.head == sel.tail);
      // link written this cycle at the address being read
      fwd_hit_r  <= link_we && (enq_tail == sel.head);
      fwd_data_r <= enq.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cur_id_r      <= '0;
      cur_prio_r    <= '0;
      cur_present_r <= 1'b0;
      count_r       <= '0;
      slot_vld_r    <= '0;
      out_valid_r   <= 1'b0;
      out_id_r      <= '0;
      out_present_r <= 1'b0;
      out_err_r     <= 1'b0;
      out_misuse_r  <= 1'b0;
      out_qst_r     <= '0;
      out_qprio_r   <= '0;
      out_live_r    <= '0;
    end else begin
      cur_id_r      <= cur_id_nxt;
      cur_prio_r    <= cur_prio_nxt;
      cur_present_r <= cur_present_nxt;
      count_r       <= count_nxt;
      if (slot_we) begin
        slot_vld_r[slot_waddr] <= 1'b1;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (commit) begin
            state_r <= in_fire ? S_EXEC : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (commit) begin
        out_valid_r   <= 1'b1;
        out_id_r      <= cur_present_nxt ? ID_W'(cur_id_nxt) : '0;
        out_present_r <= cur_present_nxt;
        out_err_r     <= empty_err;
        out_misuse_r  <= misuse;
        out_qst_r     <= q_state;
        out_qprio_r   <= q_prio;
        out_live_r    <= (32'(count_nxt) > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(count_nxt);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_running_id       = out_id_r;
  assign out_running_present  = out_present_r;
  assign out_empty_error      = out_err_r;
  assign out_misuse_flag      = out_misuse_r;
  assign out_queried_state    = out_qst_r;
  assign out_queried_priority = out_qprio_r;
  assign out_live_threads     = out_live_r;

  `PRQS_ASSERT_IMP(a_err_no_run, clk, rst_n, out_valid && out_empty_error, !out_running_present)
  `PRQS_ASSERT_IMP(a_idle_id_zero, clk, rst_n, out_valid && !out_running_present, out_running_id == '0)
  `PRQS_ASSERT_NXT(a_fire_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)
  `PRQS_ASSERT_NXT(a_commit_out, clk, rst_n, commit, out_valid_r)

endmodule

### verif/tb_priority_ready_queue_scheduler_core.sv
// Self-checking testbench for the priority ready queue scheduler core.
`timescale 1ns / 1ps

module tb_priority_ready_queue_scheduler_core;
  import prqs_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 250;
  localparam int SETTLE      = 8;
  // action codes the block treats as no operation
  localparam logic [ACT_W-1:0] ACT_NOP_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NOP_HI = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]   running_id;
    logic              running_present;
    logic              empty_error;
    logic              misuse_flag;
    logic [QST_W-1:0]  queried_state;
    logic [PRIO_W-1:0] queried_priority;
    logic [LIVE_W-1:0] live_threads;
  } status_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [ACT_W-1:0]  in_action;
  logic [ID_W-1:0]   in_thread_id;
  logic [PRIO_W-1:0] in_priority_req;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ID_W-1:0]   out_running_id;
  logic              out_running_present;
  logic              out_empty_error;
  logic              out_misuse_flag;
  logic [QST_W-1:0]  out_queried_state;
  logic [PRIO_W-1:0] out_queried_priority;
  logic [LIVE_W-1:0] out_live_threads;

  priority_ready_queue_scheduler_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_thread_id         (in_thread_id),
    .in_priority_req      (in_priority_req),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_running_id       (out_running_id),
    .out_running_present  (out_running_present),
    .out_empty_error      (out_empty_error),
    .out_misuse_flag      (out_misuse_flag),
    .out_queried_state    (out_queried_state),
    .out_queried_priority (out_queried_priority),
    .out_live_threads     (out_live_threads)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // shadow copy of the scheduler state
  logic [SLOT_W-1:0] rq_head     [LEVELS];
  logic [SLOT_W-1:0] rq_tail     [LEVELS];
  logic              rq_nonempty [LEVELS];
  logic [SLOT_W-1:0] link_nxt    [MAX_SLOTS];
  logic [LVL_W-1:0]  slot_prio   [MAX_SLOTS];
  slot_state_t       slot_st     [MAX_SLOTS];
  logic [SLOT_W-1:0] run_id;
  logic              run_valid;
  int                live_cnt;

  status_t expected_status[$];

  int gap_pct   = 0;
  int stall_pct = 0;
  int err_cnt   = 0;
  int sent_cnt  = 0;
  int checked_cnt = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  // hold-off requests from the sender side and those the receiver has taken up
  int hold_reqs = 0;
  int hold_seen = 0;

  function automatic void queue_slot(input logic [SLOT_W-1:0] slot);
    logic [LVL_W-1:0] lv;
    lv = slot_prio[slot];
    if (rq_nonempty[lv]) begin
      link_nxt[rq_tail[lv]] = slot;
    end else begin
      rq_head[lv] = slot;
      rq_nonempty[lv] = 1'b1;
    end
    rq_tail[lv] = slot;
    slot_st[slot] = ST_READY;
  endfunction

  function automatic status_t predict_status(input logic [ACT_W-1:0] act,
                                             input logic [ID_W-1:0] id,
                                             input logic [PRIO_W-1:0] pr);
    status_t s;
    logic id_ok;
    logic found;
    logic [SLOT_W-1:0] hd;
    logic [LVL_W-1:0] lvl;
    s = '0;
    found = 1'b0;
    id_ok = int'(id) < MAX_SLOTS;
    lvl = (int'(pr) >= LEVELS) ? LVL_W'(LEVELS - 1) : LVL_W'(pr);
    case (act)
      ACT_CREATE: begin
        if (id_ok && slot_st[id] == ST_FREE) begin
          slot_prio[id] = lvl;
          live_cnt++;
          queue_slot(SLOT_W'(id));
        end
      end
      ACT_ACTIVATE: begin
        if (id_ok) begin
          if (slot_st[id] == ST_READY) begin
            s.misuse_flag = 1'b1;
          end else if (slot_st[id] == ST_BLOCKED) begin
            queue_slot(SLOT_W'(id));
          end
        end
      end
      ACT_YIELD, ACT_DEACTIVATE, ACT_EXIT: begin
        if (run_valid) begin
          if (act == ACT_YIELD) begin
            queue_slot(run_id);
          end else if (act == ACT_DEACTIVATE) begin
            slot_st[run_id] = ST_BLOCKED;
          end else begin
            slot_st[run_id] = ST_FREE;
            if (live_cnt > 0) live_cnt--;
          end
        end
        // dispatch: head of the highest non-empty level
        for (int lv = LEVELS - 1; lv >= 0; lv--) begin
          if (!found && rq_nonempty[lv]) begin
            found = 1'b1;
            hd = rq_head[lv];
            if (hd == rq_tail[lv]) begin
              rq_nonempty[lv] = 1'b0;
            end else begin
              rq_head[lv] = link_nxt[hd];
            end
            slot_st[hd] = ST_RUNNING;
            run_id = hd;
          end
        end
        run_valid = found;
        if (!found) run_id = '0;
        s.empty_error = !found;
      end
      ACT_QUERY: begin
        if (id_ok && slot_st[id] != ST_FREE) begin
          s.queried_state = slot_st[id];
          s.queried_priority = PRIO_W'(slot_prio[id]);
        end else begin
          s.queried_state = ST_FREE;
        end
      end
      default: ;
    endcase
    s.running_id = run_valid ? ID_W'(run_id) : '0;
    s.running_present = run_valid;
    s.live_threads = (live_cnt > LIVE_MAX) ? LIVE_W'(LIVE_MAX) : LIVE_W'(live_cnt);
    return s;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      err_cnt++;
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // receiver: checks each status word, drives out_ready with random stalls
  always @(posedge clk) begin : status_rx
    status_t exp_s;
    if (rst_n && out_valid && out_ready) begin
      if (expected_status.size() == 0) begin
        err_cnt++;
        $display("%0t status word with no word pending: expected none, actual running_id %0d",
                 $time, out_running_id);
      end else begin
        exp_s = expected_status.pop_front();
        check_field("running_id", int'(exp_s.running_id), int'(out_running_id));
        check_field("running_present", int'(exp_s.running_present),
                    int'(out_running_present));
        check_field("empty_error", int'(exp_s.empty_error), int'(out_empty_error));
        check_field("misuse_flag", int'(exp_s.misuse_flag), int'(out_misuse_flag));
        check_field("queried_state", int'(exp_s.queried_state), int'(out_queried_state));
        check_field("queried_priority", int'(exp_s.queried_priority),
                    int'(out_queried_priority));
        check_field("live_threads", int'(exp_s.live_threads), int'(out_live_threads));
        checked_cnt++;
      end
    end
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                           input logic [PRIO_W-1:0] pr);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_thread_id <= id;
    in_priority_req <= pr;
    do @(posedge clk); while (!in_ready);
    expected_status.push_back(predict_status(act, id, pr));
    sent_cnt++;
  endtask

  // sender stops and waits for every pending status word
  task automatic drain_status;
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_idle_status;
    send_word(ACT_QUERY, 4'd15, 2'd0);       // free slot
    send_word(ACT_YIELD, 4'd0, 2'd0);        // nothing ready at all
    send_word(ACT_NOP_LO, 4'd15, 2'd3);
    send_word(ACT_NOP_HI, 4'd0, 2'd0);
  endtask

  task automatic test_create_dispatch;
    send_word(ACT_CREATE, 4'd0, 2'd0);
    send_word(ACT_CREATE, 4'd15, 2'd3);
    send_word(ACT_CREATE, 4'd5, 2'd1);
    send_word(ACT_CREATE, 4'd5, 2'd2);       // slot in use, ignored
    send_word(ACT_ACTIVATE, 4'd0, 2'd0);     // already ready: flagged
    send_word(ACT_YIELD, 4'd0, 2'd0);        // nothing running, just dispatch
  endtask

  task automatic test_activate_cases;
    send_word(ACT_ACTIVATE, 4'd15, 2'd0);    // running
    send_word(ACT_ACTIVATE, 4'd9, 2'd0);     // free
    send_word(ACT_YIELD, 4'd0, 2'd0);        // alone on top level, runs again
    send_word(ACT_QUERY, 4'd15, 2'd1);
    send_word(ACT_DEACTIVATE, 4'd0, 2'd0);
    send_word(ACT_QUERY, 4'd15, 2'd0);
    send_word(ACT_ACTIVATE, 4'd15, 2'd0);    // blocked -> ready
  endtask

  task automatic test_exit_paths;
    send_word(ACT_EXIT, 4'd0, 2'd0);
    send_word(ACT_QUERY, 4'd5, 2'd0);
    send_word(ACT_EXIT, 4'd0, 2'd0);
    send_word(ACT_EXIT, 4'd0, 2'd0);         // last one out, levels empty
    send_word(ACT_EXIT, 4'd0, 2'd0);         // nothing running, count stays
    send_word(ACT_CREATE, 4'd10, 2'd2);
    send_word(ACT_QUERY, 4'd10, 2'd0);
  endtask

  task automatic send_random_word;
    int r;
    int pick;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0] id;
    logic [PRIO_W-1:0] pr;
    r = $urandom_range(99);
    pick = $urandom_range(MAX_SLOTS - 1);
    id = ID_W'(pick);
    pr = PRIO_W'($urandom_range(3));
    if (live_cnt < 3 && r < 40) r = 0;
    if (r < 18) begin
      act = ACT_CREATE;
    end else if (r < 36) begin
      act = ACT_ACTIVATE;
      // mostly wake a blocked thread so the queues stay busy
      if ($urandom_range(99) < 65) begin
        for (int k = 0; k < MAX_SLOTS; k++) begin
          if (slot_st[SLOT_W'((pick + k) % MAX_SLOTS)] == ST_BLOCKED) begin
            id = ID_W'((pick + k) % MAX_SLOTS);
            break;
          end
        end
      end
    end else if (r < 56) begin
      act = ACT_YIELD;
    end else if (r < 66) begin
      act = ACT_DEACTIVATE;
    end else if (r < 74) begin
      act = ACT_EXIT;
    end else if (r < 93) begin
      act = ACT_QUERY;
    end else begin
      act = $urandom_range(1) ? ACT_NOP_HI : ACT_NOP_LO;
    end
    send_word(act, id, pr);
  endtask

  task automatic test_random_traffic(input int count, input int gap, input int stall,
                                     input int pause_every);
    gap_pct = gap;
    stall_pct = stall;
    for (int n = 1; n <= count; n++) begin
      send_random_word();
      if (pause_every > 0 && n % pause_every == 0) drain_status();
    end
    drain_status();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure;
    gap_pct = 0;
    stall_pct = 0;
    hold_reqs++;
    repeat (60) send_random_word();
    drain_status();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_QUERY;
    in_thread_id = '0;
    in_priority_req = '0;
    for (int i = 0; i < LEVELS; i++) begin
      rq_head[i] = '0;
      rq_tail[i] = '0;
      rq_nonempty[i] = 1'b0;
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      link_nxt[i] = '0;
      slot_prio[i] = '0;
      slot_st[i] = ST_FREE;
    end
    run_id = '0;
    run_valid = 1'b0;
    live_cnt = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 38;
    stall_pct = 38;
    test_idle_status();
    test_create_dispatch();
    test_activate_cases();
    test_exit_paths();
    drain_status();

    test_random_traffic(600, 38, 38, 0);
    test_random_traffic(400, 0, 0, 0);
    test_output_backpressure();
    test_random_traffic(800, 38, 38, 150);

    $display("Sent %0d scheduler words (directed cases, random mixes, output hold-off)",
             sent_cnt);
    $display("Compared %0d status words against the shadow scheduler", checked_cnt);
    if (err_cnt == 0 && expected_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### priority_ready_queue_scheduler_core.f
+incdir+rtl/core
rtl/core/prqs_pkg.sv
rtl/core/prqs_ram.sv
rtl/core/prqs_level_tbl.sv
rtl/core/priority_ready_queue_scheduler_core.sv
verif/tb_priority_ready_queue_scheduler_core.sv
